// ===== sv/iol_pkg.sv =====
package iol_pkg;

    // operation codes carried in s_axis_tuser
    localparam logic [1:0] KIND_APPEND  = 2'd0;
    localparam logic [1:0] KIND_INSERT  = 2'd1;
    localparam logic [1:0] KIND_PEEK    = 2'd2;
    localparam logic [1:0] KIND_EXTRACT = 2'd3;

    // fixed field widths of the stream payload
    localparam int POS_W   = 5;
    localparam int ENTRY_W = 32;
    localparam int COUNT_W = 5;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // write at target, cells above take lower neighbor
        logic ext;    // cells at and above target take upper neighbor
    } cell_ctl_t;

endpackage

// ===== sv/iol_cell.sv =====
module iol_cell
    import iol_pkg::*;
#(
    parameter int IDX = 0,
    parameter int SW  = 32,
    parameter int IW  = 4
)
(
    input  logic          clk,
    input  cell_ctl_t     ctl,
    input  logic [IW-1:0] tgt,
    input  logic [SW-1:0] din,
    input  logic [SW-1:0] lo,
    input  logic [SW-1:0] hi,
    output logic [SW-1:0] q,
    output logic [SW-1:0] rd
);

    logic [SW-1:0] data_reg;
    logic [SW-1:0] data_next;
    logic [IW-1:0] my_idx;

    assign my_idx = IW'(IDX);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (my_idx == tgt)
                data_next = din;
            else if (my_idx > tgt)
                data_next = lo;
        end
        else if (ctl.ext)
        begin
            if (my_idx >= tgt)
                data_next = hi;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q  = data_reg;
    // only the addressed cell drives the read bus
    assign rd = (my_idx == tgt) ? data_reg : '0;

endmodule

// ===== sv/indexed_ordered_list.sv =====
// Bounded ordered list of up to DEPTH entries, held in a row of cells, one entry
// per cell. A request carries one operation in s_axis_tuser: append, insert at a
// position (later entries move up one cell), peek at a position, or extract at
// a position (later entries move down one cell). Every request gives exactly one
// response with ok, the entry read (zero unless a peek or extract succeeded) and
// the count held afterwards. Appends fail when the list is full; inserts fail
// when it is full or the position is past the count; peeks and extracts fail
// at or past the count. All cells move to their neighbor in the same clock, so
// a request is accepted every cycle while the response register is empty or
// being taken, and its response appears the cycle after acceptance.
// Entries wider than ENTRY_WIDTH are cut to ENTRY_WIDTH bits (at most 32 bits
// are kept). Cell contents have no reset; count clears to zero on reset.
module indexed_ordered_list
    import iol_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[4:0], entry_in[36:5], zero pad
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // entry_out[31:0], count[36:32], zero pad
    output logic        m_axis_tuser    // ok
);

    // stored width, index width, count width, compare width
    localparam int SW = (ENTRY_WIDTH < ENTRY_W) ? ENTRY_WIDTH : ENTRY_W;
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW = $clog2(DEPTH + 1);
    localparam int CW = (HW > POS_W) ? HW : POS_W;

    // request fields
    logic [1:0]         kind;
    logic [POS_W-1:0]   position;
    logic [ENTRY_W-1:0] entry_in;

    assign kind     = s_axis_tuser;
    assign position = s_axis_tdata[POS_W-1:0];
    assign entry_in = s_axis_tdata[POS_W+ENTRY_W-1:POS_W];

    logic accept;
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // count of entries held
    logic [HW-1:0] held_reg;
    logic [HW-1:0] held_next;

    // bounds checks, in a common width
    logic [CW-1:0] pos_c;
    logic [CW-1:0] held_c;
    logic          full;
    logic          ins_ok;
    logic          rd_ok;
    logic          ok;

    assign pos_c  = CW'(position);
    assign held_c = CW'(held_reg);
    assign full   = (held_c >= CW'(DEPTH));
    // insert at the count is the same as append
    assign ins_ok = !full && (pos_c <= held_c);
    assign rd_ok  = (pos_c < held_c);

    always_comb
    begin
        unique case (kind) inside
            KIND_APPEND: ok = !full;
            KIND_INSERT: ok = ins_ok;
            KIND_PEEK,
            KIND_EXTRACT: ok = rd_ok;
            default: ok = 1'b0;
        endcase
    end

    // command to the cell row; append is an insert at the current count
    cell_ctl_t     ctl;
    logic [IW-1:0] tgt;

    assign tgt     = (kind == KIND_APPEND) ? IW'(held_reg) : IW'(position);
    assign ctl.ins = accept && ok && (kind == KIND_APPEND || kind == KIND_INSERT);
    assign ctl.ext = accept && ok && (kind == KIND_EXTRACT);

    always_comb
    begin
        held_next = held_reg;
        if (ctl.ins)
            held_next = held_reg + HW'(1);
        else if (ctl.ext)
            held_next = held_reg - HW'(1);
    end

    // row of cells, each linked to both neighbors
    logic [SW-1:0] din;
    logic [SW-1:0] cell_q  [DEPTH];
    logic [SW-1:0] cell_rd [DEPTH];

    assign din = entry_in[SW-1:0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [SW-1:0] lo;
        logic [SW-1:0] hi;

        if (i == 0)
        begin : g_first
            assign lo = '0;
        end
        else
        begin : g_mid_lo
            assign lo = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign hi = '0;
        end
        else
        begin : g_mid_hi
            assign hi = cell_q[i+1];
        end

        iol_cell #(
            .IDX (i),
            .SW  (SW),
            .IW  (IW)
        ) u_cell (
            .clk (clk),
            .ctl (ctl),
            .tgt (tgt),
            .din (din),
            .lo  (lo),
            .hi  (hi),
            .q   (cell_q[i]),
            .rd  (cell_rd[i])
        );
    end

    // read bus: only the addressed cell is nonzero
    logic [SW-1:0]      rd_any;
    logic [ENTRY_W-1:0] rd_word;

    always_comb
    begin
        rd_any = '0;
        for (int k = 0; k < DEPTH; k++)
            rd_any = rd_any | cell_rd[k];
    end

    assign rd_word = ENTRY_W'(rd_any);

    // response register
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic [ENTRY_W-1:0] out_entry_reg;
    logic [COUNT_W-1:0] out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            held_reg <= held_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_ok_reg    <= ok;
            out_entry_reg <= (ok && (kind == KIND_PEEK || kind == KIND_EXTRACT))
                             ? rd_word : '0;
            out_count_reg <= COUNT_W'(held_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, out_entry_reg};

endmodule

// ===== verif/indexed_ordered_list_tb.sv =====
`timescale 1ns / 1ps

module indexed_ordered_list_tb;
    import iol_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ENTRY_WIDTH = 32;
    localparam int RANDOM_REQS = 1100;

    // what one response of the list carries
    typedef struct packed {
        logic               ok;
        logic [ENTRY_W-1:0] entry;
        logic [COUNT_W-1:0] count;
    } list_response_t;

    // shadow copy of the list; turns each accepted request into the response it owes
    class list_scoreboard;
        logic [ENTRY_W-1:0] slots [DEPTH];
        int                 held;
        list_response_t     owed_q [$];
        int                 errors;
        int                 kind_seen [4];
        int                 rejected;
        int                 full_hits;
        int                 empty_hits;

        function new();
            held       = 0;
            errors     = 0;
            rejected   = 0;
            full_hits  = 0;
            empty_hits = 0;
            foreach (kind_seen[k])
                kind_seen[k] = 0;
            foreach (slots[k])
                slots[k] = '0;
        endfunction

        // apply one accepted request to the shadow list and queue its response
        function void note_request(logic [1:0] kind, logic [POS_W-1:0] pos,
                                   logic [ENTRY_W-1:0] entry_in);
            list_response_t rsp;
            int             i;
            int             p;
            logic [ENTRY_W-1:0] stored;
            p         = int'(pos);
            stored    = entry_in & ENTRY_W'({ENTRY_WIDTH{1'b1}});
            rsp.ok    = 1'b0;
            rsp.entry = '0;
            kind_seen[kind]++;
            if (held == DEPTH)
                full_hits++;
            if (held == 0)
                empty_hits++;
            case (kind)
                KIND_APPEND:
                begin
                    if (held < DEPTH)
                    begin
                        slots[held] = stored;
                        held++;
                        rsp.ok = 1'b1;
                    end
                end
                KIND_INSERT:
                begin
                    // a position equal to the count behaves as an append
                    if (held < DEPTH && p <= held)
                    begin
                        for (i = held; i > p; i--)
                            slots[i] = slots[i - 1];
                        slots[p] = stored;
                        held++;
                        rsp.ok = 1'b1;
                    end
                end
                KIND_PEEK:
                begin
                    if (p < held)
                    begin
                        rsp.entry = slots[p];
                        rsp.ok    = 1'b1;
                    end
                end
                default:
                begin
                    if (p < held)
                    begin
                        rsp.entry = slots[p];
                        for (i = p; i + 1 < held; i++)
                            slots[i] = slots[i + 1];
                        held--;
                        rsp.ok = 1'b1;
                    end
                end
            endcase
            if (!rsp.ok)
                rejected++;
            rsp.count = COUNT_W'(held);
            owed_q.push_back(rsp);
        endfunction

        task report_mismatch(string what, logic [ENTRY_W-1:0] got, logic [ENTRY_W-1:0] want);
            errors++;
            $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
        endtask

        // compare one accepted response against the oldest owed one
        task check_response(list_response_t got);
            list_response_t want;
            if (owed_q.size() == 0)
            begin
                report_mismatch("unexpected response", ENTRY_W'(got), '0);
                return;
            end
            want = owed_q.pop_front();
            if (got.ok !== want.ok)
                report_mismatch("ok", ENTRY_W'(got.ok), ENTRY_W'(want.ok));
            if (got.entry !== want.entry)
                report_mismatch("entry_out", got.entry, want.entry);
            if (got.count !== want.count)
                report_mismatch("count", ENTRY_W'(got.count), ENTRY_W'(want.count));
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;    // position[4:0], entry_in[36:5], zero pad
    logic [1:0]  s_axis_tuser  = '0;    // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // entry_out[31:0], count[36:32], zero pad
    logic        m_axis_tuser;          // ok

    list_scoreboard list_sb = new();

    // sender-side idle mode: when calm, requests go back to back
    bit send_calm = 1'b0;
    bit grow_mode = 1'b1;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    indexed_ordered_list #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // drive one request, optionally after an idle gap, and hold it until taken;
    // tvalid stays high across back-to-back requests so it is never dropped and
    // raised in the same step
    task send_request(logic [1:0] kind, logic [POS_W-1:0] pos, logic [ENTRY_W-1:0] entry_in);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, entry_in, pos};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        list_sb.note_request(kind, pos, entry_in);
    endtask

    // random entry value, with the all-zero and all-one extremes showing up often
    function automatic logic [ENTRY_W-1:0] pick_entry();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // one random request: mostly well-formed traffic that drifts the list between
    // empty and full, plus some noise with any kind and any 5-bit position
    task send_random_request();
        int          r;
        int          held;
        logic [1:0]  kind;
        logic [4:0]  pos;
        held = list_sb.held;
        r    = $urandom_range(0, 99);
        // turn around at the ends, sometimes lingering there first
        if (held == DEPTH && grow_mode && $urandom_range(0, 3) == 0)
            grow_mode = 1'b0;
        if (held == 0 && !grow_mode && $urandom_range(0, 3) == 0)
            grow_mode = 1'b1;
        if (r < 10)
        begin
            kind = 2'($urandom_range(0, 3));
            pos  = 5'($urandom_range(0, 31));
        end
        else if (grow_mode)
        begin
            if (r < 55)
                kind = KIND_APPEND;
            else if (r < 90)
                kind = KIND_INSERT;
            else
                kind = KIND_PEEK;
            pos = (kind == KIND_INSERT) ? 5'($urandom_range(0, held))
                                        : 5'($urandom_range(0, (held > 0) ? held - 1 : 0));
        end
        else
        begin
            if (r < 55)
                kind = KIND_EXTRACT;
            else if (r < 85)
                kind = KIND_PEEK;
            else
                kind = KIND_INSERT;
            pos = (kind == KIND_INSERT) ? 5'($urandom_range(0, held))
                                        : 5'($urandom_range(0, (held > 0) ? held - 1 : 0));
        end
        send_request(kind, pos, pick_entry());
    endtask

    // response side: stall for a random number of cycles per response,
    // with calm stretches where it takes every cycle
    initial
    begin : response_sink
        int  stall;
        bit  take_calm;
        take_calm = 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // sample accepted responses at the edge that takes them
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            list_sb.check_response({m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32]});
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("timeout with %0d responses still owed", list_sb.owed_q.size());
        $display("indexed_ordered_list verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        int wait_cycles;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list bounds, then inserts, peeks and extracts at the edges
        send_request(KIND_PEEK,    5'd0,  32'h0000_0001);
        send_request(KIND_EXTRACT, 5'd0,  32'h0000_0002);
        send_request(KIND_INSERT,  5'd1,  32'hDEAD_BEEF);  // past the end on empty
        send_request(KIND_INSERT,  5'd0,  32'h0000_0000);
        send_request(KIND_APPEND,  5'd31, 32'hFFFF_FFFF);
        send_request(KIND_INSERT,  5'd2,  32'hA5A5_5A5A);  // at the count, acts as append
        send_request(KIND_INSERT,  5'd1,  32'h1234_5678);  // middle, later entries shift up
        send_request(KIND_PEEK,    5'd4,  32'h0);          // exactly at the count
        send_request(KIND_PEEK,    5'd3,  32'h0);          // last entry
        send_request(KIND_PEEK,    5'd31, 32'h0);
        send_request(KIND_EXTRACT, 5'd0,  32'h0);          // first, rest shift down
        send_request(KIND_EXTRACT, 5'd2,  32'h0);          // last
        send_request(KIND_INSERT,  5'd16, 32'h0);
        // fill to capacity, then hit the full list
        while (list_sb.held < DEPTH)
            send_request(KIND_APPEND, 5'd0, pick_entry());
        send_request(KIND_APPEND,  5'd0,  32'h5555_5555);
        send_request(KIND_INSERT,  5'd0,  32'hAAAA_AAAA);
        send_request(KIND_INSERT,  5'd16, 32'hAAAA_AAAA);
        send_request(KIND_PEEK,    5'd15, 32'h0);
        send_request(KIND_EXTRACT, 5'd15, 32'h0);
        send_request(KIND_EXTRACT, 5'd16, 32'h0);

        for (n = 0; n < RANDOM_REQS; n++)
            send_random_request();

        s_axis_tvalid <= 1'b0;
        // drain: every owed response must come back
        wait_cycles = 0;
        while (list_sb.owed_q.size() != 0 && wait_cycles < 10_000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4) @(posedge clk);
        if (list_sb.owed_q.size() != 0)
            list_sb.report_mismatch("missing responses", list_sb.owed_q.size(), 0);

        $display("requests: %0d append, %0d insert, %0d peek, %0d extract, %0d rejected",
                 list_sb.kind_seen[KIND_APPEND], list_sb.kind_seen[KIND_INSERT],
                 list_sb.kind_seen[KIND_PEEK], list_sb.kind_seen[KIND_EXTRACT],
                 list_sb.rejected);
        $display("list seen full %0d times and empty %0d times, %0d mismatches",
                 list_sb.full_hits, list_sb.empty_hits, list_sb.errors);
        if (list_sb.errors == 0)
            $display("indexed_ordered_list verification clean");
        else
            $display("indexed_ordered_list verification failed");
        $finish;
    end

endmodule
